FILE: rtl/core/clti_pkg.sv
// ----------------------------------------------------------------------------
// clti_pkg
// Shared types and constants for the clamped linear table interpolator.
// ----------------------------------------------------------------------------
package clti_pkg;

    localparam int Q_W   = 32;   // Q16.16 word
    localparam int FRAC  = 16;   // fraction bits
    localparam int W_W   = 17;   // interpolation weight, 0..65536
    localparam int CFG_W = 7;    // entries_in_use register
    localparam int IDX_W = 6;    // load slot field
    localparam int STEP_W = 5;   // divider step counter

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // one table row: breakpoint angle with its two coefficients
    typedef struct packed {
        logic [Q_W-1:0] angle;
        logic [Q_W-1:0] drag;
        logic [Q_W-1:0] lift;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] num;
        logic [Q_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [W_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: rtl/core/clti_in_if.sv
// ----------------------------------------------------------------------------
// clti_in_if
// Input channel: query or load transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clti_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic        [clti_pkg::IDX_W-1:0]   entry_index;
    logic signed [clti_pkg::Q_W-1:0]     angle;
    logic signed [clti_pkg::Q_W-1:0]     drag_value;
    logic signed [clti_pkg::Q_W-1:0]     lift_value;

    modport source (
        output valid, operation, entry_index, angle, drag_value, lift_value,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, angle, drag_value, lift_value,
        output ready
    );
endinterface

FILE: rtl/core/clti_out_if.sv
// ----------------------------------------------------------------------------
// clti_out_if
// Output channel: interpolated drag and lift with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clti_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [clti_pkg::Q_W-1:0] drag_coeff;
    logic signed [clti_pkg::Q_W-1:0] lift_coeff;

    modport source (
        output valid, drag_coeff, lift_coeff,
        input  ready
    );
    modport sink (
        input  valid, drag_coeff, lift_coeff,
        output ready
    );
endinterface

FILE: rtl/core/clti_ram.sv
// ----------------------------------------------------------------------------
// clti_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clti_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/clti_div.sv
// ----------------------------------------------------------------------------
// clti_div
// Restoring divider for the weight floor(num * 2^16 / den), num <= den.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module clti_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clti_pkg::t_div_req i_req,
    output clti_pkg::t_div_rsp o_rsp
);

    localparam int QW = clti_pkg::Q_W;
    localparam int WW = clti_pkg::W_W;
    localparam int SW = clti_pkg::STEP_W;

    logic          r_busy;
    logic [SW-1:0] r_step;
    logic [QW:0]   r_rem;
    logic [QW-1:0] r_den;
    logic [WW-1:0] r_quo;

    logic [QW:0]   n_trial;
    logic          n_ge;
    logic [QW:0]   n_rem;
    logic [WW-1:0] n_quo;
    logic          n_last;

    always_comb begin
        // first step tests the integer bit, no shift
        n_trial = (r_step == '0) ? r_rem : {r_rem[QW-1:0], 1'b0};
        n_ge    = n_trial >= {1'b0, r_den};
        n_rem   = n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
        n_quo   = {r_quo[WW-2:0], n_ge};
        n_last  = r_step == SW'(WW - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= {1'b0, i_req.num};
                r_den  <= i_req.den;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_step <= r_step + 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_busy && n_last;
    assign o_rsp.quo  = n_quo;

endmodule

FILE: rtl/core/clamped_linear_table_interpolator.sv
// ----------------------------------------------------------------------------
// clamped_linear_table_interpolator
// Piecewise-linear lookup of drag and lift against angle, Q16.16 throughout.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per handshake. A load (operation = 1) writes
//   angle, drag and lift into slot entry_index and gives no result; slots
//   at or above MAX_ENTRIES are dropped. A query (operation = 0) gives one
//   result on o_out.
//   i_cfg_wr_en / i_cfg_wr_data write entries_in_use (reset value 1); write it
//   only while no query is in flight.
//   Query flow: the scan reads one table row per S_READ/S_SCAN pair from the
//   single table RAM, stopping at the first breakpoint not below the angle.
//   A clamped result goes straight to S_OUT; an interpolated one also passes
//   the bit-serial divider (S_DIV) and the shared multiplier (S_MUL/S_ACC,
//   once for drag and once for lift) before S_OUT.
//   One query is processed at a time; i_in.ready is high only when idle.
//   The result sits in an output register, so a new transaction is taken
//   while o_out is stalled; a second result waits until it drains.
//   Reset clears control state and sets entries_in_use to 1. Table contents
//   are undefined until loaded.
// ----------------------------------------------------------------------------
module clamped_linear_table_interpolator #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [clti_pkg::CFG_W-1:0]   i_cfg_wr_data,
    clti_in_if.sink                      i_in,
    clti_out_if.source                   o_out
);

    localparam int QW = clti_pkg::Q_W;
    localparam int WW = clti_pkg::W_W;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > clti_pkg::CFG_W) ? CW : clti_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [clti_pkg::CFG_W-1:0] r_cfg;
    logic [CW-1:0]             r_n;
    logic [CW-1:0]             r_cnt;
    logic signed [QW-1:0]      r_x;
    clti_pkg::t_entry          r_lo;
    clti_pkg::t_entry          r_hi;
    logic [WW-1:0]             r_w;
    logic                      r_sel;
    logic [QW-1:0]             r_prod;
    logic [QW-1:0]             r_res_drag;
    logic [QW-1:0]             r_res_lift;
    logic                      r_out_valid;
    logic [QW-1:0]             r_out_drag;
    logic [QW-1:0]             r_out_lift;

    clti_pkg::t_entry   rd_entry;
    clti_pkg::t_entry   wr_entry;
    logic               in_fire;
    logic               wr_en;
    logic [XW-1:0]      cfg_x;
    logic [XW-1:0]      n_count;
    logic               hit;
    logic               last_row;
    clti_pkg::t_div_req div_req;
    clti_pkg::t_div_rsp div_rsp;
    logic [QW-1:0]      v_lo;
    logic [QW-1:0]      v_hi;
    logic signed [QW:0] diff;
    logic signed [QW+WW+1:0] prod;

    assign in_fire = i_in.valid && i_in.ready;
    assign wr_en   = in_fire && (i_in.operation == clti_pkg::OP_LOAD)
                     && ({26'd0, i_in.entry_index} < 32'(MAX_ENTRIES));

    assign wr_entry.angle = i_in.angle;
    assign wr_entry.drag  = i_in.drag_value;
    assign wr_entry.lift  = i_in.lift_value;

    clti_ram #(
        .WIDTH (clti_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in.entry_index)),
        .i_wr_data (wr_entry),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (rd_entry)
    );

    // entries in use clamped to 1..MAX_ENTRIES
    always_comb begin
        cfg_x = XW'(r_cfg);
        if (cfg_x == '0) begin
            n_count = XW'(1);
        end else if (cfg_x > XW'(MAX_ENTRIES)) begin
            n_count = XW'(MAX_ENTRIES);
        end else begin
            n_count = cfg_x;
        end
    end

    assign hit      = $signed(rd_entry.angle) >= r_x;
    assign last_row = r_cnt == CW'(r_n - 1'b1);

    assign div_req.start = (r_state == S_SCAN) && (r_n != CW'(1)) && hit
                           && (r_cnt != '0);
    assign div_req.num   = QW'(r_x - $signed(r_lo.angle));
    assign div_req.den   = rd_entry.angle - r_lo.angle;

    clti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // one multiplier shared by drag (sel 0) and lift (sel 1)
    always_comb begin
        v_lo = r_sel ? r_lo.lift : r_lo.drag;
        v_hi = r_sel ? r_hi.lift : r_hi.drag;
        diff = $signed({v_hi[QW-1], v_hi}) - $signed({v_lo[QW-1], v_lo});
        prod = $signed({1'b0, r_w}) * diff;
    end

    assign i_in.ready       = r_state == S_IDLE;
    assign o_out.valid      = r_out_valid;
    assign o_out.drag_coeff = r_out_drag;
    assign o_out.lift_coeff = r_out_lift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= clti_pkg::CFG_W'(1);
            r_n         <= CW'(1);
            r_cnt       <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            // S_OUT refills the output register itself
            if (o_out.valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_in.operation == clti_pkg::OP_QUERY)) begin
                        r_n     <= n_count[CW-1:0];
                        r_cnt   <= '0;
                        r_x     <= i_in.angle;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_n == CW'(1) || (hit && r_cnt == '0) || (!hit && last_row)) begin
                        // clamped: the row just read is the answer
                        r_res_drag <= rd_entry.drag;
                        r_res_lift <= rd_entry.lift;
                        r_state    <= S_OUT;
                    end else if (hit) begin
                        r_hi    <= rd_entry;
                        r_state <= S_DIV;
                    end else begin
                        r_lo    <= rd_entry;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_w     <= div_rsp.quo;
                        r_sel   <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= prod[QW+clti_pkg::FRAC-1:clti_pkg::FRAC];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // floor of the product by 2^16 is the arithmetic shift
                    if (r_sel) begin
                        r_res_lift <= v_lo + r_prod;
                        r_state    <= S_OUT;
                    end else begin
                        r_res_drag <= v_lo + r_prod;
                        r_sel      <= 1'b1;
                        r_state    <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_drag  <= r_res_drag;
                        r_out_lift  <= r_res_lift;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in.operation == clti_pkg::OP_QUERY) |=> !i_in.ready)
        else $error("query transaction did not start processing");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt < r_n) && (r_n != '0))
        else $error("scan index beyond entries in use");

    a_div_start_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_cnt != '0) && $signed(r_lo.angle) < r_x)
        else $error("divider started without a lower breakpoint below the angle");

endmodule

FILE: tb/sv/clamped_linear_table_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clamped_linear_table_interpolator_tb
// Self-checking bench for the drag/lift lookup table. It loads breakpoint
// tables of several shapes and sizes, sweeps the entry count and compares
// every interpolated result with an in-bench Q16.16 model.
// ----------------------------------------------------------------------------
module clamped_linear_table_interpolator_tb;

    localparam int   Q_W      = clti_pkg::Q_W;
    localparam int   FRAC     = clti_pkg::FRAC;
    localparam int   CFG_W    = clti_pkg::CFG_W;
    localparam int   IDX_W    = clti_pkg::IDX_W;
    localparam logic OP_QUERY = clti_pkg::OP_QUERY;
    localparam logic OP_LOAD  = clti_pkg::OP_LOAD;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 160;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int LONG_HOLD     = 400;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;

    typedef longint unsigned t_u64;

    typedef enum int {TBL_WIDE, TBL_FINE, TBL_UNIT, TBL_UNSORTED} t_table_shape;

    typedef struct packed {
        logic                   op;
        logic [IDX_W-1:0]       idx;
        logic signed [Q_W-1:0]  angle;
        logic signed [Q_W-1:0]  drag;
        logic signed [Q_W-1:0]  lift;
    } t_table_txn;

    typedef struct packed {
        logic signed [Q_W-1:0]  drag;
        logic signed [Q_W-1:0]  lift;
    } t_coeff;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    clti_in_if  in_if ();
    clti_out_if out_if ();

    clamped_linear_table_interpolator #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if.sink),
        .o_out         (out_if.source)
    );

    // bench copy of the block state
    logic signed [Q_W-1:0] bp_angle [TABLE_DEPTH];
    logic signed [Q_W-1:0] bp_drag  [TABLE_DEPTH];
    logic signed [Q_W-1:0] bp_lift  [TABLE_DEPTH];
    logic [CFG_W-1:0]      entries_reg;
    t_coeff                expected_coeffs [$];

    int  errors          = 0;
    int  loads_sent      = 0;
    int  queries_sent    = 0;
    int  results_checked = 0;
    int  count_writes    = 0;
    int  idle_cycles     = 0;
    int  hold_request    = 0;
    bit  src_idle_on     = 1'b1;
    bit  sink_idle_on    = 1'b1;

    always #6 i_clk = ~i_clk;

    function automatic t_u64 rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(longint v);
        if (v < longint'(Q_MIN)) return Q_MIN;
        if (v > longint'(Q_MAX)) return Q_MAX;
        return Q_W'(v);
    endfunction

    function automatic logic signed [Q_W-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int active_entries();
        if (entries_reg == 0) return 1;
        if (entries_reg > TABLE_DEPTH) return TABLE_DEPTH;
        return int'(entries_reg);
    endfunction

    // lo + floor(w * (hi - lo) / 2^16)
    function automatic logic signed [Q_W-1:0] blend_q16(logic signed [Q_W-1:0] lo,
                                                       logic signed [Q_W-1:0] hi,
                                                       longint w);
        longint base;
        longint span;
        base = lo;
        span = longint'(hi) - base;
        return Q_W'(base + ((w * span) >>> FRAC));
    endfunction

    function automatic t_coeff interpolate(logic signed [Q_W-1:0] x);
        int     n;
        int     hi_i;
        int     lo_i;
        longint xs;
        longint a1;
        longint a2;
        longint w;
        t_u64   num;
        t_u64   den;
        t_coeff r;
        n = active_entries();
        hi_i = 0;
        if (n > 1) begin
            while (hi_i < n) begin
                if (bp_angle[hi_i] >= x) break;
                hi_i++;
            end
        end
        if (n == 1 || hi_i == 0) begin
            r.drag = bp_drag[0];
            r.lift = bp_lift[0];
        end else if (hi_i == n) begin
            r.drag = bp_drag[n-1];
            r.lift = bp_lift[n-1];
        end else begin
            lo_i = hi_i - 1;
            xs = x;
            a1 = bp_angle[lo_i];
            a2 = bp_angle[hi_i];
            num = t_u64'(xs - a1);
            den = t_u64'(a2 - a1);
            w = longint'((num << FRAC) / den);
            if (w > 65536) w = 65536;
            r.drag = blend_q16(bp_drag[lo_i], bp_drag[hi_i], w);
            r.lift = blend_q16(bp_lift[lo_i], bp_lift[hi_i], w);
        end
        return r;
    endfunction

    // query angles: half inside an interval, the rest random, on or next to breakpoints, or past either end
    function automatic logic signed [Q_W-1:0] pick_query_angle(int n);
        int     k;
        longint lo;
        longint hi;
        longint t;
        t_u64   span;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return bp_angle[k];
            2: return sat_q(longint'(bp_angle[k]) + longint'($urandom_range(0, 6)) - 3);
            3: return sat_q(longint'(bp_angle[0]) - longint'($urandom_range(1, 1000)));
            4: return sat_q(longint'(bp_angle[n-1]) + longint'($urandom_range(1, 1000)));
            default: begin
                if (n < 2) return $urandom;
                k = $urandom_range(0, n - 2);
                lo = bp_angle[k];
                hi = bp_angle[k+1];
                if (lo > hi) begin
                    t = lo;
                    lo = hi;
                    hi = t;
                end
                span = t_u64'(hi - lo) + 1;
                return Q_W'(lo + longint'(rand64() % span));
            end
        endcase
    endfunction

    // one transaction on the input channel; the model is updated at acceptance
    task automatic send_txn(input t_table_txn t);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= t.op;
        in_if.entry_index <= t.idx;
        in_if.angle       <= t.angle;
        in_if.drag_value  <= t.drag;
        in_if.lift_value  <= t.lift;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (t.op == OP_LOAD) begin
            bp_angle[t.idx] = t.angle;
            bp_drag[t.idx]  = t.drag;
            bp_lift[t.idx]  = t.lift;
            loads_sent++;
        end else begin
            expected_coeffs.push_back(interpolate(t.angle));
            queries_sent++;
        end
    endtask

    task automatic send_load(input int slot, input logic signed [Q_W-1:0] a,
                             input logic signed [Q_W-1:0] d,
                             input logic signed [Q_W-1:0] l);
        t_table_txn t;
        t.op    = OP_LOAD;
        t.idx   = IDX_W'(slot);
        t.angle = a;
        t.drag  = d;
        t.lift  = l;
        send_txn(t);
    endtask

    task automatic send_query(input logic signed [Q_W-1:0] x);
        t_table_txn t;
        t.op    = OP_QUERY;
        t.idx   = IDX_W'($urandom);
        t.angle = x;
        t.drag  = $urandom;
        t.lift  = $urandom;
        send_txn(t);
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_coeffs.size() != 0) @(posedge i_clk);
    endtask

    // register write only with the block idle; loads leave nothing to wait on
    task automatic write_entries(input int value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        entries_reg = CFG_W'(value);
        count_writes++;
    endtask

    task automatic load_table(input int n, input t_table_shape shape);
        longint                offs [TABLE_DEPTH];
        longint                base;
        t_u64                  max_step;
        logic signed [Q_W-1:0] ang;
        int                    slot;
        bit                    reverse;
        case (shape)
            TBL_WIDE: max_step = (t_u64'(64'd4294967295) - t_u64'(n)) / t_u64'(n);
            TBL_UNIT: max_step = t_u64'(1) << 17;
            default:  max_step = 3;   // fine steps, duplicates likely
        endcase
        offs[0] = 0;
        for (int i = 1; i < n; i++)
            offs[i] = offs[i-1] + longint'(rand64() % (max_step + 1));
        base = longint'(Q_MIN)
             + longint'(rand64() % (t_u64'(64'd4294967296) - t_u64'(offs[n-1])));
        reverse = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
            slot = reverse ? n - 1 - k : k;
            if (shape == TBL_UNSORTED) ang = rand_coeff();
            else ang = Q_W'(base + offs[slot]);
            send_load(slot, ang, rand_coeff(), rand_coeff());
        end
    endtask

    task automatic run_table_session(input int n, input t_table_shape shape, input int queries);
        logic [CFG_W-1:0] code;
        load_table(n, shape);
        code = CFG_W'(n);
        if (n == 1 && $urandom_range(0, 3) == 0) code = '0;
        if (n == TABLE_DEPTH && $urandom_range(0, 2) == 0)
            code = CFG_W'($urandom_range(TABLE_DEPTH + 1, (1 << CFG_W) - 1));
        write_entries(code);
        for (int q = 0; q < queries; q++) begin
            if ($urandom_range(0, 15) == 0)
                send_load($urandom_range(0, TABLE_DEPTH - 1), $urandom, rand_coeff(),
                          rand_coeff());
            else
                send_query(pick_query_angle(n));
        end
    endtask

    task automatic test_single_entry();
        send_load(0, 32'sh0001_0000, Q_MAX, Q_MIN);
        send_query(Q_MIN);
        send_query(Q_MAX);
        send_query('0);
        write_entries(0);   // zero count acts as one entry
        send_query(32'sh0001_0000);
    endtask

    task automatic test_breakpoint_corners();
        send_load(0, Q_MIN, Q_MAX, Q_MIN);
        send_load(1, -32'sd65536, Q_MIN, Q_MAX);
        send_load(2, 32'sd65536, 32'sd12345, '0);
        send_load(3, Q_MAX, -32'sd1, 32'sd7);
        write_entries(4);
        send_query(Q_MIN);          // at first breakpoint, clamps low
        send_query(Q_MIN + 1);      // tiny weight, full-scale difference
        send_query(-32'sd65536);    // exactly on a breakpoint, weight of one
        send_query('0);             // half weight
        send_query(32'sd65537);
        send_query(Q_MAX);
        write_entries(3);
        send_query(Q_MAX);          // past the last entry, clamps high
        write_entries(2);
        send_query('0);
    endtask

    task automatic test_entry_count_limits();
        load_table(TABLE_DEPTH, TBL_WIDE);
        write_entries((1 << CFG_W) - 1);   // saturates at the table depth
        repeat (12) send_query(pick_query_angle(TABLE_DEPTH));
        write_entries(TABLE_DEPTH + 1);
        repeat (6) send_query(pick_query_angle(TABLE_DEPTH));
        write_entries(TABLE_DEPTH);
        repeat (6) send_query(pick_query_angle(TABLE_DEPTH));
        write_entries(0);
        repeat (4) send_query(pick_query_angle(1));
    endtask

    task automatic test_unsorted_table();
        load_table(24, TBL_UNSORTED);
        write_entries(24);
        repeat (60) send_query(pick_query_angle(24));
    endtask

    // sink holds off while queries keep coming, so the input stalls
    task automatic test_output_backpressure();
        load_table(8, TBL_UNIT);
        write_entries(8);
        src_idle_on  = 1'b0;
        hold_request = LONG_HOLD;
        repeat (16) send_query(pick_query_angle(8));
        src_idle_on  = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (10) send_query(pick_query_angle(8));
        wait_results_drained();
        repeat (10) send_query(pick_query_angle(8));
    endtask

    task automatic test_random_tables();
        int start_items;
        int n;
        int pick;
        start_items = loads_sent + queries_sent;
        while (loads_sent + queries_sent - start_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) n = 1;
            else if (pick <= 6) n = $urandom_range(2, 8);
            else if (pick <= 8) n = $urandom_range(9, 32);
            else n = TABLE_DEPTH;
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            run_table_session(n, t_table_shape'($urandom_range(0, 3)), $urandom_range(20, 60));
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        in_if.valid       = 1'b0;
        in_if.operation   = OP_QUERY;
        in_if.entry_index = '0;
        in_if.angle       = '0;
        in_if.drag_value  = '0;
        in_if.lift_value  = '0;
        entries_reg       = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_entry();
        test_breakpoint_corners();
        test_entry_count_limits();
        test_unsorted_table();
        test_output_backpressure();
        test_drain_pause();
        test_random_tables();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d loads and %0d queries over %0d entry-count writes,",
                 loads_sent, queries_sent, count_writes);
        $display("with clamped, exact and interpolated lookups; %0d results checked.",
                 results_checked);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls per transaction, one long hold on request
    initial begin : result_checker
        int     stall;
        t_coeff want;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = sink_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            results_checked++;
            if (expected_coeffs.size() == 0) begin
                $error("unexpected result: drag_coeff %0d lift_coeff %0d",
                       out_if.drag_coeff, out_if.lift_coeff);
                errors++;
            end else begin
                want = expected_coeffs.pop_front();
                if (out_if.drag_coeff !== want.drag) begin
                    $error("drag_coeff: expected %0d, actual %0d", want.drag, out_if.drag_coeff);
                    errors++;
                end
                if (out_if.lift_coeff !== want.lift) begin
                    $error("lift_coeff: expected %0d, actual %0d", want.lift, out_if.lift_coeff);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
